/* sv/fxa_pkg.sv */
// package: command codes, constants and shared types for the q24.8 alu
package fxa_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_MIN  = 4'd4,
    CMD_MAX  = 4'd5,
    CMD_CMP  = 4'd6,
    CMD_INC  = 4'd7,
    CMD_DEC  = 4'd8,
    CMD_ITOF = 4'd9,
    CMD_FTOI = 4'd10
  } cmd_e;

  typedef struct packed {
    logic a_greater;
    logic a_less;
    logic a_equal;
  } cmp_flags_t;

endpackage

/* sv/fxa_if.sv */
// interfaces: operation and result channels with valid/ready handshake
interface fxa_op_if;
  import fxa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic signed [DataW-1:0] operand_a;
  logic signed [DataW-1:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fxa_res_if;
  import fxa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_value;
  logic                    a_greater;
  logic                    a_less;
  logic                    a_equal;
  logic                    divide_by_zero;
  modport source (output valid, result_value, a_greater, a_less, a_equal,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_value, a_greater, a_less, a_equal,
                  divide_by_zero, output ready);
endinterface

/* sv/fxa_mul.sv */
// pipelined signed 32x32 multiplier: partial products of 16-bit halves, sum, shift
module fxa_mul
  import fxa_pkg::*;
#(
  parameter int unsigned FracBits = 8
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [DataW-1:0] a_i,
  input  logic signed [DataW-1:0] b_i,
  output logic [DataW-1:0]        prod_o
);
  localparam int unsigned HW = DataW / 2;

  // stage 1: four partial products, signed high halves
  logic signed [DataW:0]   ll_q, lh_q, hl_q, hh_q;
  logic signed [DataW:0]   ll_d, lh_d, hl_d, hh_d;
  logic signed [HW:0]      al, bl, ah, bh;
  assign al = $signed({1'b0, a_i[HW-1:0]});
  assign bl = $signed({1'b0, b_i[HW-1:0]});
  assign ah = $signed({a_i[DataW-1], a_i[DataW-1:HW]});
  assign bh = $signed({b_i[DataW-1], b_i[DataW-1:HW]});
  always_comb begin
    ll_d = (DataW+1)'(al * bl);
    lh_d = (DataW+1)'(al * bh);
    hl_d = (DataW+1)'(ah * bl);
    hh_d = (DataW+1)'(ah * bh);
  end

  // stage 2: combine and shift
  logic signed [2*DataW-1:0] full;
  assign full = (2*DataW)'(ll_q) + ((2*DataW)'(lh_q) <<< HW)
              + ((2*DataW)'(hl_q) <<< HW) + ((2*DataW)'(hh_q) <<< DataW);

  logic [DataW-1:0] prod_d, prod_q;
  logic [2*DataW-1:0] sh;
  assign sh     = full >>> FracBits;
  assign prod_d = sh[DataW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= ll_d;
      lh_q   <= lh_d;
      hl_q   <= hl_d;
      hh_q   <= hh_d;
      prod_q <= prod_d;
    end
  end
  assign prod_o = prod_q;
endmodule

/* sv/fxa_div.sv */
// pipelined restoring divider on magnitudes, several quotient bits per stage
module fxa_div
  import fxa_pkg::*;
#(
  parameter int unsigned FracBits = 8,
  parameter int unsigned Stages   = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output logic [DataW-1:0] quot_o
);
  localparam int unsigned NW  = DataW + FracBits;       // numerator magnitude width
  localparam int unsigned BPS = (NW + Stages - 1) / Stages;
  localparam int unsigned TW  = BPS * Stages;

  logic        neg;
  logic [DataW-1:0] amag, bmag;
  assign neg  = a_i[DataW-1] ^ b_i[DataW-1];
  assign amag = a_i[DataW-1] ? DataW'(-a_i) : a_i;
  assign bmag = b_i[DataW-1] ? DataW'(-b_i) : b_i;

  // per stage: remainder, remaining numerator bits, divisor, sign
  logic [DataW:0]   rem_q [Stages+1];
  logic [TW-1:0]    num_q [Stages+1];
  logic [DataW-1:0] dvs_q [Stages+1];
  logic             neg_q [Stages+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = TW'({amag, {FracBits{1'b0}}});
    dvs_q[0] = bmag;
    neg_q[0] = neg;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DataW:0]   r;
    logic [TW-1:0]    n;
    always_comb begin
      r = rem_q[s];
      n = num_q[s];
      for (int k = 0; k < BPS; k++) begin
        r = {r[DataW-1:0], n[TW-1]};
        n = {n[TW-2:0], 1'b0};
        if (r >= {1'b0, dvs_q[s]}) begin
          r    = r - {1'b0, dvs_q[s]};
          n[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r;
        num_q[s+1] <= n;
        dvs_q[s+1] <= dvs_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  logic [DataW-1:0] q;
  assign q      = num_q[Stages][DataW-1:0];
  assign quot_o = neg_q[Stages] ? DataW'(-q) : q;
endmodule

/* sv/fixed_point_q24_8_alu.sv */
// top level: pipelined q24.8 fixed-point alu with valid/ready channels
//
//  channel | dir | fields                                           | handshake
//  op_i    | in  | command, operand_a, operand_b                    | valid/ready
//  res_o   | out | result_value, a_greater, a_less, a_equal, dbz    | valid/ready
//
// a result passes the issue register, which loads when its operation transfers,
// then the divider's eight stages and the output register.
// one operation enters every cycle while the output is not stalled.
// all commands run the same pipeline, so results stay in order.
// reset clears every valid bit; payload registers are not reset.
// a stall at the output freezes the whole pipeline; ready is low only then.
module fixed_point_q24_8_alu
  import fxa_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fxa_op_if.sink     op_i,
  fxa_res_if.source  res_o
);
  localparam int unsigned DivStages = 8;
  localparam int unsigned Depth     = DivStages;

  logic en;
  assign en       = !res_o.valid || res_o.ready;
  assign op_i.ready = en;

  // issue register
  logic                    v0_q;
  logic [CmdW-1:0]         cmd0_q;
  logic signed [DataW-1:0] a0_q, b0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= op_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= op_i.command;
      a0_q   <= op_i.operand_a;
      b0_q   <= op_i.operand_b;
    end
  end

  // simple ops evaluated after issue
  logic [DataW-1:0] simple;
  logic             dz;
  cmp_flags_t       flg;
  always_comb begin
    flg.a_greater = a0_q > b0_q;
    flg.a_less    = a0_q < b0_q;
    flg.a_equal   = a0_q == b0_q;
    dz            = 1'b0;
    case (cmd0_q)
      CMD_ADD:  simple = DataW'(a0_q + b0_q);
      CMD_SUB:  simple = DataW'(a0_q - b0_q);
      CMD_MIN:  simple = flg.a_less ? a0_q : b0_q;
      CMD_MAX:  simple = flg.a_less ? b0_q : a0_q;
      CMD_INC:  simple = DataW'(a0_q + 1);
      CMD_DEC:  simple = DataW'(a0_q - 1);
      CMD_ITOF: simple = DataW'(a0_q <<< FRACTION_BITS);
      CMD_FTOI: simple = DataW'(a0_q >>> FRACTION_BITS);
      CMD_DIV: begin
        simple = a0_q;
        dz     = (b0_q == '0);
      end
      default:  simple = '0;
    endcase
  end

  // delay line carrying valid, command, simple results, divide-by-zero and flags alongside the units
  logic             v_q   [Depth];
  logic [CmdW-1:0]  c_q   [Depth];
  logic [DataW-1:0] s_q   [Depth];
  logic             z_q   [Depth];
  cmp_flags_t       f_q   [Depth];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= v0_q;
      for (int i = 1; i < Depth; i++) v_q[i] <= v_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0] <= cmd0_q;
      s_q[0] <= simple;
      z_q[0] <= dz;
      f_q[0] <= flg;
      for (int i = 1; i < Depth; i++) begin
        c_q[i] <= c_q[i-1];
        s_q[i] <= s_q[i-1];
        z_q[i] <= z_q[i-1];
        f_q[i] <= f_q[i-1];
      end
    end
  end

  // multiplier: two stages, result realigned to the divider's exit
  logic [DataW-1:0] prod;
  fxa_mul #(.FracBits(FRACTION_BITS)) u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a0_q),
    .b_i    (b0_q),
    .prod_o (prod)
  );
  logic [DataW-1:0] pd_q [DivStages-2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q[0] <= prod;
      for (int i = 1; i < DivStages-2; i++) pd_q[i] <= pd_q[i-1];
    end
  end

  // divider: eight stages starting at the issue register
  logic [DataW-1:0] quot;
  fxa_div #(.FracBits(FRACTION_BITS), .Stages(DivStages)) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (a0_q),
    .b_i    (b0_q),
    .quot_o (quot)
  );

  // output register
  logic             rv_q;
  logic [DataW-1:0] rval_q, rval_d;
  cmp_flags_t       rf_q;
  logic             rz_q;
  always_comb begin
    case (c_q[DivStages-1])
      CMD_MUL: rval_d = pd_q[DivStages-3];
      CMD_DIV: rval_d = z_q[DivStages-1] ? s_q[DivStages-1] : quot;
      default: rval_d = s_q[DivStages-1];
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= v_q[DivStages-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rval_q <= rval_d;
      rf_q   <= f_q[DivStages-1];
      rz_q   <= z_q[DivStages-1];
    end
  end

  assign res_o.valid          = rv_q;
  assign res_o.result_value   = rval_q;
  assign res_o.a_greater      = rf_q.a_greater;
  assign res_o.a_less         = rf_q.a_less;
  assign res_o.a_equal        = rf_q.a_equal;
  assign res_o.divide_by_zero = rz_q;

  // exactly one comparison flag is set on a valid result
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $onehot({rf_q.a_greater, rf_q.a_less, rf_q.a_equal}))
    else $error("comparison flags not exclusive");
  // divide-by-zero only on a divide
  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DivStages-1] && z_q[DivStages-1]) |-> c_q[DivStages-1] == CMD_DIV)
    else $error("divide-by-zero on non-divide");
  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !res_o.ready) |=> (rv_q && $stable(rval_q)))
    else $error("result changed under stall");
endmodule
